>>> sv/psp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Types, codes and helpers shared by the PSI section parser modules.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int unsigned POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

  // Header byte positions (table id byte is position 0)
  localparam logic [POS_W-1:0] POS_SEC_LEN  = 12'd2;
  localparam logic [POS_W-1:0] POS_HDR_WORD = 12'd4;
  localparam logic [POS_W-1:0] POS_PAT_VER  = 12'd5;
  localparam logic [POS_W-1:0] POS_PMT_INFO = 12'd11;

  // First entry start positions after each header
  localparam logic [13:0] PAT_FIRST_ENTRY = 14'd8;
  localparam logic [13:0] PMT_FIRST_ENTRY = 14'd12;

  typedef enum logic [1:0] {
    KIND_PAT_HDR    = 2'd0,
    KIND_PAT_PROG   = 2'd1,
    KIND_PMT_HDR    = 2'd2,
    KIND_PMT_STREAM = 2'd3
  } record_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_LOOP = 3'd2,
    PH_ENT1 = 3'd3,
    PH_ENT2 = 3'd4,
    PH_ENT3 = 3'd5,
    PH_ENT4 = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       action;
  } in_item_t;

  typedef struct packed {
    record_kind_e record_kind;
    logic [15:0]  value_a;
    logic [12:0]  value_b;
    logic [11:0]  value_c;
    logic         last_record;
  } rec_t;

  // Entry of 4 (PAT) or 5 (PMT) bytes starting at start must end before the CRC
  function automatic logic fits_entry(logic [13:0] start, logic [11:0] sect, logic pmt);
    logic [13:0] need;
    need = start + (pmt ? 14'd5 : 14'd4) + 14'd1;
    return need <= {2'b00, sect};
  endfunction

endpackage

>>> sv/psp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_in_if / psp_out_if
// Valid/ready channels for section bytes in and parsed records out.
// ----------------------------------------------------------------------------
interface psp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       action;

  modport source (output valid, data_byte, first_byte, action, input ready);
  modport sink   (input valid, data_byte, first_byte, action, output ready);
endinterface

interface psp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] value_a;
  logic [12:0] value_b;
  logic [11:0] value_c;
  logic        last_record;

  modport source (output valid, record_kind, value_a, value_b, value_c, last_record,
                  input ready);
  modport sink   (input valid, record_kind, value_a, value_b, value_c, last_record,
                  output ready);
endinterface

>>> sv/psi_section_parser_core.sv
`timescale 1ns / 1ps
// Registers: a byte loads the input register at its transfer, and its record
//   loads the result register when the parser consumes the byte (held if stalled).
// Throughput: one section byte per cycle while the result register has room; the
//   parse logic between the two registers is combinational.
// Reset (async, active low) clears all parser state and both stage valids.
// ----------------------------------------------------------------------------
// psi_section_parser_core
// PAT / PMT section parser: section bytes in, header and entry records out.
// ----------------------------------------------------------------------------
module psi_section_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  psp_in_if.sink     in_i,
  psp_out_if.source  out_o
);

  logic              item_valid;
  psp_pkg::in_item_t item;
  logic              take;
  logic              room;
  logic              push;
  psp_pkg::rec_t     rec;

  psp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  psp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .room_i       (room),
    .take_o       (take),
    .push_o       (push),
    .rec_o        (rec)
  );

  psp_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

>>> sv/psp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_in_stage
// Input register: holds one section byte until the parser consumes it.
// ----------------------------------------------------------------------------
module psp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  psp_in_if.sink             in_i,
  input  logic               take_i,
  output logic               valid_o,
  output psp_pkg::in_item_t  item_o
);

  logic              valid_q;
  psp_pkg::in_item_t item_q;

  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.data_byte  <= in_i.data_byte;
      item_q.first_byte <= in_i.first_byte;
      item_q.action     <= in_i.action;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/psp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_parser
// Section state machine: tracks byte position, header fields, skips and
// entry bytes, and builds at most one record per consumed byte.
// ----------------------------------------------------------------------------
module psp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  psp_pkg::in_item_t  item_i,
  input  logic               room_i,
  output logic               take_o,
  output logic               push_o,
  output psp_pkg::rec_t      rec_o
);

  psp_pkg::phase_e phase_q, phase_d;
  logic [11:0] byte_position_q, byte_position_d;
  logic [11:0] section_bytes_q, section_bytes_d;
  logic [11:0] skip_count_q, skip_count_d;
  logic [23:0] field_shift_q, field_shift_d;
  logic [15:0] header_word_q, header_word_d;
  logic        is_pmt_q, is_pmt_d;
  logic [11:0] entry_index_q, entry_index_d;

  logic        fire;
  logic [23:0] shift_new;
  logic [11:0] pos_inc;
  logic        pat_hdr_done;
  logic        pmt_hdr_done;
  logic        fit_here;
  logic        emit;
  psp_pkg::rec_t rec;

  assign fire      = item_valid_i && room_i;
  assign take_o    = fire;
  assign shift_new = {field_shift_q[15:0], item_i.data_byte};
  assign pos_inc   = (byte_position_q != psp_pkg::POS_MAX) ? byte_position_q + 12'd1
                                                           : byte_position_q;
  assign pat_hdr_done = (pos_inc == psp_pkg::POS_PAT_VER) && !is_pmt_q;
  assign pmt_hdr_done = (pos_inc == psp_pkg::POS_PMT_INFO) && is_pmt_q;
  assign fit_here = psp_pkg::fits_entry({2'b00, pos_inc}, section_bytes_q, is_pmt_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      if (item_i.first_byte) begin
        phase_d = psp_pkg::PH_HEAD;
      end else begin
        unique case (phase_q)
          psp_pkg::PH_IDLE: phase_d = psp_pkg::PH_IDLE;
          psp_pkg::PH_HEAD: begin
            if (pat_hdr_done || pmt_hdr_done) phase_d = psp_pkg::PH_LOOP;
          end
          psp_pkg::PH_LOOP: begin
            if (skip_count_q == 12'd0) begin
              phase_d = fit_here ? psp_pkg::PH_ENT1 : psp_pkg::PH_IDLE;
            end
          end
          psp_pkg::PH_ENT1: phase_d = psp_pkg::PH_ENT2;
          psp_pkg::PH_ENT2: phase_d = psp_pkg::PH_ENT3;
          psp_pkg::PH_ENT3: phase_d = is_pmt_q ? psp_pkg::PH_ENT4 : psp_pkg::PH_LOOP;
          psp_pkg::PH_ENT4: phase_d = psp_pkg::PH_LOOP;
          default:          phase_d = psp_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Datapath and record
  always_comb begin
    logic [11:0] info;
    logic [13:0] start;
    info            = shift_new[11:0];
    start           = 14'd0;
    byte_position_d = byte_position_q;
    section_bytes_d = section_bytes_q;
    skip_count_d    = skip_count_q;
    field_shift_d   = field_shift_q;
    header_word_d   = header_word_q;
    is_pmt_d        = is_pmt_q;
    entry_index_d   = entry_index_q;
    emit            = 1'b0;
    rec             = '0;
    if (fire) begin
      field_shift_d = shift_new;
      if (item_i.first_byte) begin
        byte_position_d = 12'd0;
        is_pmt_d        = item_i.action;
        section_bytes_d = 12'd0;
        skip_count_d    = 12'd0;
        header_word_d   = 16'd0;
        entry_index_d   = 12'd0;
      end else if (phase_q != psp_pkg::PH_IDLE) begin
        byte_position_d = pos_inc;
        unique case (phase_q)
          psp_pkg::PH_HEAD: begin
            if (pos_inc == psp_pkg::POS_SEC_LEN) begin
              section_bytes_d = shift_new[11:0];
            end else if (pos_inc == psp_pkg::POS_HDR_WORD) begin
              header_word_d = shift_new[15:0];
            end else if (pat_hdr_done) begin
              skip_count_d        = 12'd2;
              emit                = 1'b1;
              rec.record_kind     = psp_pkg::KIND_PAT_HDR;
              rec.value_a         = header_word_q;
              rec.value_b         = {8'd0, item_i.data_byte[5:1]};
              rec.value_c         = section_bytes_q;
              rec.last_record     = !psp_pkg::fits_entry(psp_pkg::PAT_FIRST_ENTRY,
                                                         section_bytes_q, is_pmt_q);
            end else if (pmt_hdr_done) begin
              skip_count_d        = info;
              start               = psp_pkg::PMT_FIRST_ENTRY + {2'b00, info};
              emit                = 1'b1;
              rec.record_kind     = psp_pkg::KIND_PMT_HDR;
              rec.value_a         = header_word_q;
              rec.value_b         = {1'b0, section_bytes_q};
              rec.value_c         = info;
              rec.last_record     = !psp_pkg::fits_entry(start, section_bytes_q, is_pmt_q);
            end
          end
          psp_pkg::PH_LOOP: begin
            if (skip_count_q != 12'd0) skip_count_d = skip_count_q - 12'd1;
          end
          psp_pkg::PH_ENT1: header_word_d = shift_new[15:0];
          psp_pkg::PH_ENT3: begin
            if (!is_pmt_q) begin
              skip_count_d    = 12'd0;
              start           = {2'b00, pos_inc} + 14'd1;
              emit            = 1'b1;
              rec.record_kind = psp_pkg::KIND_PAT_PROG;
              rec.value_a     = header_word_q;
              rec.value_b     = shift_new[12:0];
              rec.value_c     = entry_index_q;
              rec.last_record = !psp_pkg::fits_entry(start, section_bytes_q, is_pmt_q);
              entry_index_d   = entry_index_q + 12'd1;
            end
          end
          psp_pkg::PH_ENT4: begin
            skip_count_d    = info;
            start           = {2'b00, pos_inc} + 14'd1 + {2'b00, info};
            emit            = 1'b1;
            rec.record_kind = psp_pkg::KIND_PMT_STREAM;
            rec.value_a     = {8'd0, header_word_q[15:8]};
            rec.value_b     = {header_word_q[4:0], shift_new[23:16]};
            rec.value_c     = info;
            rec.last_record = !psp_pkg::fits_entry(start, section_bytes_q, is_pmt_q);
            entry_index_d   = entry_index_q + 12'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= psp_pkg::PH_IDLE;
      byte_position_q <= 12'd0;
      section_bytes_q <= 12'd0;
      skip_count_q    <= 12'd0;
      field_shift_q   <= 24'd0;
      header_word_q   <= 16'd0;
      is_pmt_q        <= 1'b0;
      entry_index_q   <= 12'd0;
    end else begin
      phase_q         <= phase_d;
      byte_position_q <= byte_position_d;
      section_bytes_q <= section_bytes_d;
      skip_count_q    <= skip_count_d;
      field_shift_q   <= field_shift_d;
      header_word_q   <= header_word_d;
      is_pmt_q        <= is_pmt_d;
      entry_index_q   <= entry_index_d;
    end
  end

  assign push_o = fire && emit;
  assign rec_o  = rec;

  // Outside a section nothing is produced
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && phase_q == psp_pkg::PH_IDLE && !item_i.first_byte) |-> !emit)
    else $error("record produced outside a section");

  // Every record leaves the parser waiting between entries
  a_emit_to_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> (phase_q == psp_pkg::PH_LOOP))
    else $error("record not followed by entry loop");

  // A pending skip only exists between entries
  a_skip_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_count_q != 12'd0) |-> (phase_q == psp_pkg::PH_LOOP))
    else $error("skip count live outside entry loop");

  // Header records come before any entry of the section
  a_hdr_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && (rec.record_kind == psp_pkg::KIND_PAT_HDR ||
                      rec.record_kind == psp_pkg::KIND_PMT_HDR))
      |-> (entry_index_q == 12'd0))
    else $error("header record after entries");

endmodule

>>> sv/psp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_out_stage
// Result register: holds one record until the sink takes it.
// ----------------------------------------------------------------------------
module psp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psp_pkg::rec_t  rec_i,
  output logic           room_o,
  psp_out_if.source      out_o
);

  logic          valid_q;
  psp_pkg::rec_t rec_q;

  assign room_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.record_kind = rec_q.record_kind;
  assign out_o.value_a     = rec_q.value_a;
  assign out_o.value_b     = rec_q.value_b;
  assign out_o.value_c     = rec_q.value_c;
  assign out_o.last_record = rec_q.last_record;

endmodule
